/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros used by the tagged_header_block_parser design file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// implication checked at every clock edge out of reset
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

`endif

/* design/thbp_pkg.sv */
// ---------------------------------------------------------------------------
// thbp_pkg
// types, codes and the tag table of the tagged header block parser
// ---------------------------------------------------------------------------
package thbp_pkg;

    // status codes carried with a result item
    localparam logic [1:0] ST_RUN      = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_BADMAGIC = 2'd2;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_header;
    } thbp_in_t;

    // result item
    typedef struct packed {
        logic        write_valid;
        logic [10:0] record_offset;
        logic [7:0]  record_byte;
        logic [1:0]  status;
    } thbp_out_t;

    // lookup result for one block tag
    typedef struct packed {
        logic        hit;
        logic [10:0] offset;
        logic [8:0]  limit;
    } thbp_tag_info_t;

    // expected magic byte for a field position ('TAFF')
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] res;
        case (idx)
            2'd0:    res = 8'h54;
            2'd1:    res = 8'h41;
            default: res = 8'h46;
        endcase
        return res;
    endfunction

    // known tags with their record offset and copy limit
    function automatic thbp_tag_info_t tag_lookup(input logic [31:0] tag);
        thbp_tag_info_t res;
        res = '{hit: 1'b1, offset: 11'd0, limit: 9'd0};
        case (tag)
            32'h39CB44F1: begin res.offset = 11'd0;    res.limit = 9'h004; end
            32'h2C2381CF: begin res.offset = 11'd4;    res.limit = 9'h005; end
            32'h37F9D612: begin res.offset = 11'd16;   res.limit = 9'h040; end
            32'h8578C004: begin res.offset = 11'd80;   res.limit = 9'h108; end
            32'h0F992DFE: begin res.offset = 11'd344;  res.limit = 9'h018; end
            32'h66C65056: begin res.offset = 11'd368;  res.limit = 9'h060; end
            32'h6AEBB196: begin res.offset = 11'd464;  res.limit = 9'h060; end
            32'h1CE68F50: begin res.offset = 11'd560;  res.limit = 9'h1B8; end
            32'hC7708CDA: begin res.offset = 11'd1000; res.limit = 9'h150; end
            default:      res.hit = 1'b0;
        endcase
        return res;
    endfunction

endpackage

/* design/tagged_header_block_parser.sv */
// ---------------------------------------------------------------------------
// tagged_header_block_parser
// parses a 'TAFF' archive header byte by byte into record writes and status
// ---------------------------------------------------------------------------
//  channel | dir | payload     | handshake
//  s_      | in  | thbp_in_t   | s_valid / s_ready
//  m_      | out | thbp_out_t  | m_valid / m_ready
//
//  one input item per cycle while s_ready is high; an item is decoded against the field counters
//  and its result, if any, lands in the output register on the next edge
//  an item is accepted whenever the output register is empty or being taken
//  items that cause no result leave the output register untouched
//  reset (aresetn low, synchronous) returns the parser to the magic field
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tagged_header_block_parser
    import thbp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  thbp_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output thbp_out_t m_data
);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_COUNT,
        PH_TAG,
        PH_LEN,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  fbc_reg, fbc_next;
    logic        magic_ok_reg, magic_ok_next;
    logic [31:0] blocks_left_reg, blocks_left_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] payload_left_reg, payload_left_next;
    logic [8:0]  copy_left_reg, copy_left_next;
    logic [10:0] dest_reg, dest_next;
    logic        m_valid_reg, m_valid_next;
    thbp_out_t   m_data_reg, m_data_next;

    phase_t         ph;
    logic [1:0]     fbc;
    logic           magic_ok;
    logic           accept;
    logic           last_byte;
    logic [7:0]     b;
    logic [31:0]    len_full;
    thbp_tag_info_t tinfo;
    logic           wv;
    logic [1:0]     st;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // start mark restarts the parser on this byte
    assign ph        = s_data.start_header ? PH_MAGIC : phase_reg;
    assign fbc       = s_data.start_header ? 2'd0 : fbc_reg;
    assign magic_ok  = s_data.start_header ? 1'b1 : magic_ok_reg;
    assign b         = s_data.data_byte;
    assign last_byte = (fbc == 2'd3);
    assign len_full  = {b, payload_left_reg[31:8]};
    assign tinfo     = tag_lookup(tag_reg);

    // field decode for one item
    always_comb begin
        phase_next        = phase_reg;
        fbc_next          = fbc_reg;
        magic_ok_next     = magic_ok_reg;
        blocks_left_next  = blocks_left_reg;
        tag_next          = tag_reg;
        payload_left_next = payload_left_reg;
        copy_left_next    = copy_left_reg;
        dest_next         = dest_reg;
        wv                = 1'b0;
        st                = ST_RUN;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        if (accept) begin
            phase_next    = ph;
            fbc_next      = fbc + 2'd1;
            magic_ok_next = magic_ok;
            case (ph)
                PH_MAGIC: begin
                    if (b != magic_byte(fbc)) begin
                        magic_ok_next = 1'b0;
                    end
                    if (last_byte) begin
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    blocks_left_next = {b, blocks_left_reg[31:8]};
                    if (last_byte) begin
                        if (!magic_ok) begin
                            phase_next = PH_DONE;
                            st         = ST_BADMAGIC;
                        end else if (blocks_left_next == 32'd0) begin
                            phase_next = PH_DONE;
                            st         = ST_COMPLETE;
                        end else begin
                            phase_next = PH_TAG;
                        end
                    end
                end
                PH_TAG: begin
                    tag_next = {b, tag_reg[31:8]};
                    if (last_byte) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    payload_left_next = len_full;
                    if (last_byte) begin
                        // copy length is the smaller of block length and tag limit, or zero for an unknown tag
                        if (!tinfo.hit) begin
                            copy_left_next = 9'd0;
                            dest_next      = 11'd0;
                        end else begin
                            dest_next = tinfo.offset;
                            if (len_full < {23'd0, tinfo.limit}) begin
                                copy_left_next = len_full[8:0];
                            end else begin
                                copy_left_next = tinfo.limit;
                            end
                        end
                        if (len_full == 32'd0) begin
                            blocks_left_next = blocks_left_reg - 32'd1;
                            if (blocks_left_reg == 32'd1) begin
                                phase_next = PH_DONE;
                                st         = ST_COMPLETE;
                            end else begin
                                phase_next = PH_TAG;
                            end
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    fbc_next = 2'd0;
                    if (copy_left_reg != 9'd0) begin
                        wv             = 1'b1;
                        dest_next      = dest_reg + 11'd1;
                        copy_left_next = copy_left_reg - 9'd1;
                    end
                    payload_left_next = payload_left_reg - 32'd1;
                    if (payload_left_reg == 32'd1) begin
                        blocks_left_next = blocks_left_reg - 32'd1;
                        if (blocks_left_reg == 32'd1) begin
                            phase_next = PH_DONE;
                            st         = ST_COMPLETE;
                        end else begin
                            phase_next = PH_TAG;
                        end
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                    fbc_next   = fbc;
                end
            endcase

            // result item only for a record write or the end of the header
            if (wv || st != ST_RUN) begin
                m_valid_next              = 1'b1;
                m_data_next.write_valid   = wv;
                m_data_next.record_offset = wv ? dest_reg : 11'd0;
                m_data_next.record_byte   = wv ? b : 8'd0;
                m_data_next.status        = st;
            end
        end
    end

    // state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_MAGIC;
            fbc_reg          <= 2'd0;
            magic_ok_reg     <= 1'b1;
            blocks_left_reg  <= 32'd0;
            tag_reg          <= 32'd0;
            payload_left_reg <= 32'd0;
            copy_left_reg    <= 9'd0;
            dest_reg         <= 11'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            fbc_reg          <= fbc_next;
            magic_ok_reg     <= magic_ok_next;
            blocks_left_reg  <= blocks_left_next;
            tag_reg          <= tag_next;
            payload_left_reg <= payload_left_next;
            copy_left_reg    <= copy_left_next;
            dest_reg         <= dest_next;
            m_valid_reg      <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    // checks on the parser state and results
    `ASSERT_IMPLY(a_result_has_cause, m_valid_reg, m_data_reg.write_valid || m_data_reg.status != ST_RUN, "result item without write or status")
    `ASSERT_IMPLY(a_no_write_on_bad_magic, m_valid_reg && m_data_reg.write_valid, m_data_reg.status != ST_BADMAGIC, "record write with bad magic status")
    `ASSERT_IMPLY(a_payload_nonzero, phase_reg == PH_PAYLOAD, payload_left_reg != 32'd0, "payload phase with nothing left")
    `ASSERT_IMPLY(a_copy_within_payload, phase_reg == PH_PAYLOAD, 32'(copy_left_reg) <= payload_left_reg, "copy count exceeds payload count")

endmodule
